// ----- design/slt_pkg.sv -----
// package for the sorted leaf table: constants, codes and types
package slt_pkg;
    localparam int LeafCapacity  = 32;
    localparam int MaxKeyWords   = 3;
    localparam int MaxValueWords = 2;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_READ   = 2'd2,
        KIND_LBOUND = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_SPLIT     = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    localparam logic CFG_KEY_WORDS   = 1'b0;
    localparam logic CFG_VALUE_WORDS = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_CHK_RD,
        S_CHK_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_OUT
    } t_state;
endpackage

// ----- design/sorted_leaf_table.sv -----
// sorted leaf table top level: record store, search and shift sequencer
// lookup: binary search, then a check read of the found slot; lower-bound skips the check
// insert shifts the records above the slot up one at a time; a full leaf then emits its upper half
// one item at a time; the record memory (one read or write port) sets the rate
// synchronous active-low reset clears the record count and control state and sets both config registers
// memory contents stay undefined until written
module sorted_leaf_table
    import slt_pkg::*;
#(
    parameter int LEAF_CAPACITY   = slt_pkg::LeafCapacity,
    parameter int MAX_KEY_WORDS   = slt_pkg::MaxKeyWords,
    parameter int MAX_VALUE_WORDS = slt_pkg::MaxValueWords
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [63:0] i_key_word_0,
    input  logic [63:0] i_key_word_1,
    input  logic [63:0] i_key_word_2,
    input  logic [63:0] i_value_word_0,
    input  logic [63:0] i_value_word_1,
    input  logic [5:0]  i_position,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_result_position,
    output logic [63:0] o_out_key_0,
    output logic [63:0] o_out_key_1,
    output logic [63:0] o_out_key_2,
    output logic [63:0] o_out_value_0,
    output logic [63:0] o_out_value_1,
    output logic        o_last
);
    localparam int KW    = MAX_KEY_WORDS;
    localparam int VW    = (MAX_VALUE_WORDS > 0) ? MAX_VALUE_WORDS : 1;
    localparam int RecW  = 64 * (KW + VW);
    localparam int AW    = (LEAF_CAPACITY > 1) ? $clog2(LEAF_CAPACITY) : 1;
    localparam int CW    = $clog2(LEAF_CAPACITY + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0] r_kw, r_vw;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi, r_idx, n_idx;
    logic [CW-1:0] r_cur, n_cur, r_n, n_n;
    logic [1:0] r_kind;
    logic [64*KW-1:0] r_key;
    logic [64*VW-1:0] r_val;
    logic [5:0] r_pos;
    logic [RecW-1:0] r_tmp, n_tmp;
    logic r_full, n_full;

    logic we;
    logic [AW-1:0] addr;
    logic [RecW-1:0] wdata, rdata;

    logic [2:0] r_ostat, n_ostat;
    logic [5:0] r_opos, n_opos;
    logic [RecW-1:0] r_orec, n_orec;
    logic r_orec_en, n_orec_en;
    logic r_olast, n_olast;

    logic [2:0] kw_eff;
    logic [2:0] vw_eff;
    logic lt, eq;
    logic [CW-1:0] mid, middle;
    logic [64*KW-1:0] key_in;
    logic [64*VW-1:0] val_in;
    logic [CW:0] sum;

    slt_ram #(.Width(RecW), .Depth(LEAF_CAPACITY)) u_rec (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    always_comb begin
        kw_eff = (r_kw == 2'd0) ? 3'd1 : {1'b0, r_kw};
        if (kw_eff > 3'(KW)) kw_eff = 3'(KW);
        vw_eff = {1'b0, r_vw};
        if (vw_eff > 3'(MAX_VALUE_WORDS)) vw_eff = 3'(MAX_VALUE_WORDS);
    end

    // lexicographic compare of stored record against the item key
    always_comb begin
        logic done;
        lt = 1'b0;
        done = 1'b0;
        for (int j = 0; j < KW; j++) begin
            if (!done && 3'(j) < kw_eff) begin
                if (rdata[64*j +: 64] < r_key[64*j +: 64]) begin
                    lt = 1'b1;
                    done = 1'b1;
                end else if (rdata[64*j +: 64] > r_key[64*j +: 64]) begin
                    done = 1'b1;
                end
            end
        end
        eq = !done;
    end

    always_comb begin
        key_in = '0;
        key_in[63:0] = i_key_word_0;
        if (KW > 1) key_in[64 +: 64] = i_key_word_1;
        if (KW > 2) key_in[128 +: 64] = i_key_word_2;
        val_in = '0;
        val_in[63:0] = i_value_word_0;
        if (VW > 1) val_in[64 +: 64] = i_value_word_1;
    end

    assign sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid = sum[CW:1];
    assign middle = CW'((LEAF_CAPACITY + 1) / 2);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_lo = r_lo;
        n_hi = r_hi;
        n_idx = r_idx;
        n_cur = r_cur;
        n_n = r_n;
        n_tmp = r_tmp;
        n_full = r_full;
        n_ostat = r_ostat;
        n_opos = r_opos;
        n_orec = r_orec;
        n_orec_en = r_orec_en;
        n_olast = r_olast;
        we = 1'b0;
        addr = mid[AW-1:0];
        wdata = {r_val, r_key};
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_lo = '0;
                    n_hi = r_count;
                    if (t_kind'(i_kind) == KIND_READ) begin
                        n_cur = CW'(i_position);
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_SRCH_RD;
                    end
                end
            end
            S_SRCH_RD: begin
                if (r_lo < r_hi) begin
                    addr = mid[AW-1:0];
                    n_state = S_SRCH_CMP;
                end else begin
                    n_idx = r_lo;
                    n_state = S_DECIDE;
                end
            end
            S_SRCH_CMP: begin
                if (lt) n_lo = mid + CW'(1);
                else n_hi = mid;
                n_state = S_SRCH_RD;
            end
            S_DECIDE: begin
                if (t_kind'(r_kind) == KIND_LBOUND) begin
                    n_ostat = ST_OK;
                    n_opos = 6'(r_idx);
                    n_orec_en = 1'b0;
                    n_olast = 1'b1;
                    n_state = S_OUT;
                end else if (r_idx < r_count) begin
                    addr = r_idx[AW-1:0];
                    n_state = S_CHK_RD;
                end else begin
                    n_state = S_CHK_CMP;
                end
            end
            S_CHK_RD: n_state = S_CHK_CMP;
            S_CHK_CMP: begin
                n_opos = 6'(r_idx);
                n_olast = 1'b1;
                if (r_idx < r_count && eq) begin
                    n_ostat = (t_kind'(r_kind) == KIND_LOOKUP) ? ST_OK : ST_DUPLICATE;
                    n_orec = rdata;
                    n_orec_en = 1'b1;
                    n_state = S_OUT;
                end else if (t_kind'(r_kind) == KIND_LOOKUP) begin
                    n_ostat = ST_NOT_FOUND;
                    n_orec_en = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_full = (r_count == CW'(LEAF_CAPACITY));
                    if (r_count == CW'(LEAF_CAPACITY)) begin
                        n_tmp = {r_val, r_key};
                        n_cur = r_count - CW'(1);
                    end else begin
                        n_cur = r_count;
                    end
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                // capture the last record before the split shift
                if (r_full && r_n == '0 && r_cur == r_count - CW'(1)
                        && r_idx != r_count) begin
                    addr = r_cur[AW-1:0];
                    n_state = S_SHIFT_WR;
                end else if (r_cur > r_idx) begin
                    addr = AW'(r_cur - CW'(1));
                    n_state = S_SHIFT_WR;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_SHIFT_WR: begin
                if (r_full && r_cur == r_count - CW'(1) && r_idx != r_count
                        && r_n == '0) begin
                    n_tmp = rdata;
                    n_n = CW'(1);
                end else begin
                    we = 1'b1;
                    addr = r_cur[AW-1:0];
                    wdata = rdata;
                    n_cur = r_cur - CW'(1);
                end
                n_state = S_SHIFT_RD;
            end
            S_PUT: begin
                if (!(r_full && r_idx == r_count)) begin
                    we = 1'b1;
                    addr = r_idx[AW-1:0];
                end
                if (r_full) begin
                    n_cur = middle;
                    n_n = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_count = r_count + CW'(1);
                    n_ostat = ST_OK;
                    n_opos = 6'(r_idx);
                    n_orec = {r_val, r_key};
                    n_orec_en = 1'b1;
                    n_olast = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_EMIT_RD: begin
                addr = r_cur[AW-1:0];
                n_state = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (r_full) begin
                    n_ostat = ST_SPLIT;
                    n_opos = 6'(r_n);
                    n_orec = (r_cur == CW'(LEAF_CAPACITY)) ? r_tmp : rdata;
                    n_orec_en = 1'b1;
                    n_olast = (r_cur == CW'(LEAF_CAPACITY));
                end else begin
                    n_opos = 6'(r_cur);
                    n_olast = 1'b1;
                    if (r_cur < r_count) begin
                        n_ostat = ST_OK;
                        n_orec = rdata;
                        n_orec_en = 1'b1;
                    end else begin
                        n_ostat = ST_RANGE;
                        n_orec_en = 1'b0;
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_full && !r_olast) begin
                        n_cur = r_cur + CW'(1);
                        n_n = r_n + CW'(1);
                        n_state = S_EMIT_RD;
                    end else begin
                        if (r_full) n_count = middle;
                        n_full = 1'b0;
                        n_n = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_kw <= 2'd3;
            r_vw <= 2'd0;
            r_full <= 1'b0;
            r_n <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_full <= n_full;
            r_n <= n_n;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_KEY_WORDS) r_kw <= i_cfg_data;
                else r_vw <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        r_idx <= n_idx;
        r_cur <= n_cur;
        r_tmp <= n_tmp;
        r_ostat <= n_ostat;
        r_opos <= n_opos;
        r_orec <= n_orec;
        r_orec_en <= n_orec_en;
        r_olast <= n_olast;
        if (r_state == S_IDLE && i_valid) begin
            r_kind <= i_kind;
            r_key <= key_in;
            r_val <= val_in;
            r_pos <= i_position;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_ostat;
    assign o_result_position = r_opos;
    assign o_last = r_olast;

    always_comb begin
        o_out_key_0 = '0;
        o_out_key_1 = '0;
        o_out_key_2 = '0;
        o_out_value_0 = '0;
        o_out_value_1 = '0;
        if (r_orec_en) begin
            o_out_key_0 = r_orec[63:0];
            if (KW > 1 && kw_eff > 3'd1) o_out_key_1 = r_orec[64 +: 64];
            if (KW > 2 && kw_eff > 3'd2) o_out_key_2 = r_orec[128 +: 64];
            if (MAX_VALUE_WORDS > 0 && vw_eff > 3'd0)
                o_out_value_0 = r_orec[64*KW +: 64];
            if (MAX_VALUE_WORDS > 1 && vw_eff > 3'd1)
                o_out_value_1 = r_orec[64*KW + 64 +: 64];
        end
    end

    // read position is held for the whole item
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_OUT) |=> $stable(r_pos))
        else $error("position changed mid item");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LEAF_CAPACITY))
        else $error("record count above capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)))
        else $error("result dropped while stalled");
endmodule

// ----- design/slt_ram.sv -----
// generic single port ram with registered read
module slt_ram #(
    parameter int Width = 64,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- dv/tb.sv -----
// testbench for sorted_leaf_table: directed table and random items against a leaf model
module tb;
    import slt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit  = 3000;
    localparam int DrainWait  = 200;
    localparam int HoldCycles = 300;

    typedef logic [2:0][63:0] t_key;
    typedef logic [1:0][63:0] t_value;

    typedef struct packed {
        t_kind      kind;
        t_key       key;
        t_value     val;
        logic [5:0] pos;
    } t_op;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  pos;
        t_key        key;
        t_value      val;
        logic        last;
    } t_res;

    typedef struct packed {
        t_op        op;
        logic       typed;
        logic [2:0] status;
        logic [5:0] pos;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = '0;
    logic [63:0] i_key_word_0 = '0;
    logic [63:0] i_key_word_1 = '0;
    logic [63:0] i_key_word_2 = '0;
    logic [63:0] i_value_word_0 = '0;
    logic [63:0] i_value_word_1 = '0;
    logic [5:0]  i_position = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [1:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [5:0]  o_result_position;
    logic [63:0] o_out_key_0, o_out_key_1, o_out_key_2;
    logic [63:0] o_out_value_0, o_out_value_1;
    logic        o_last;

    sorted_leaf_table DUT (.*);

    always #5 i_clk = ~i_clk;

    // leaf model state
    t_key       leaf_key [LeafCapacity];
    t_value     leaf_val [LeafCapacity];
    int         leaf_count = 0;
    logic [1:0] reg_key_words = 2'd3;
    logic [1:0] reg_value_words = 2'd0;

    t_res pending_results[$];
    t_res op_results[$];
    int   errors = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   splits_seen = 0;
    bit   quiet = 0;
    bit   hold_req = 0;

    function automatic int key_words_eff();
        if (reg_key_words == 0) return 1;
        if (reg_key_words > MaxKeyWords) return MaxKeyWords;
        return reg_key_words;
    endfunction

    function automatic int value_words_eff();
        if (reg_value_words > MaxValueWords) return MaxValueWords;
        return reg_value_words;
    endfunction

    function automatic int compare_at(int p, t_key key);
        for (int i = 0; i < key_words_eff(); i++) begin
            if (leaf_key[p][i] < key[i]) return -1;
            if (leaf_key[p][i] > key[i]) return 1;
        end
        return 0;
    endfunction

    function automatic int lower_bound(t_key key);
        int lo, hi, mid;
        lo = 0;
        hi = leaf_count;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (compare_at(mid, key) < 0) lo = mid + 1; else hi = mid;
        end
        return lo;
    endfunction

    function automatic t_res make_result(t_status st, int p, t_key k, t_value v, logic lst);
        t_res r;
        for (int j = 0; j < 3; j++) if (j >= key_words_eff()) k[j] = '0;
        for (int j = 0; j < 2; j++) if (j >= value_words_eff()) v[j] = '0;
        r.status = st;
        r.pos = p[5:0];
        r.key = k;
        r.val = v;
        r.last = lst;
        return r;
    endfunction

    task automatic apply_leaf_op(t_op op);
        int idx, total, middle, n;
        t_key tk;
        t_value tv;
        op_results.delete();
        if (op.kind == KIND_READ) begin
            if (op.pos < leaf_count)
                op_results.push_back(make_result(ST_OK, op.pos, leaf_key[op.pos],
                                                 leaf_val[op.pos], 1'b1));
            else
                op_results.push_back(make_result(ST_RANGE, op.pos, '0, '0, 1'b1));
            return;
        end
        idx = lower_bound(op.key);
        if (op.kind == KIND_LBOUND) begin
            op_results.push_back(make_result(ST_OK, idx, '0, '0, 1'b1));
            return;
        end
        if (idx < leaf_count && compare_at(idx, op.key) == 0) begin
            op_results.push_back(make_result(op.kind == KIND_LOOKUP ? ST_OK : ST_DUPLICATE,
                                             idx, leaf_key[idx], leaf_val[idx], 1'b1));
            return;
        end
        if (op.kind == KIND_LOOKUP) begin
            op_results.push_back(make_result(ST_NOT_FOUND, idx, '0, '0, 1'b1));
            return;
        end
        if (leaf_count < LeafCapacity) begin
            for (int i = leaf_count; i > idx; i--) begin
                leaf_key[i] = leaf_key[i-1];
                leaf_val[i] = leaf_val[i-1];
            end
            leaf_key[idx] = op.key;
            leaf_val[idx] = op.val;
            leaf_count++;
            op_results.push_back(make_result(ST_OK, idx, op.key, op.val, 1'b1));
            return;
        end
        total = leaf_count + 1;
        middle = (leaf_count + 1) / 2;
        n = 0;
        if (idx == leaf_count) begin
            tk = op.key;
            tv = op.val;
        end else begin
            tk = leaf_key[leaf_count-1];
            tv = leaf_val[leaf_count-1];
            for (int i = leaf_count - 1; i > idx; i--) begin
                leaf_key[i] = leaf_key[i-1];
                leaf_val[i] = leaf_val[i-1];
            end
            leaf_key[idx] = op.key;
            leaf_val[idx] = op.val;
        end
        for (int i = middle; i < total; i++) begin
            if (i < leaf_count)
                op_results.push_back(make_result(ST_SPLIT, n, leaf_key[i], leaf_val[i],
                                                 i + 1 == total));
            else
                op_results.push_back(make_result(ST_SPLIT, n, tk, tv, i + 1 == total));
            n++;
        end
        leaf_count = middle;
        splits_seen++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 64'($urandom_range(0, 3));
            default: return rand64();
        endcase
    endfunction

    function automatic t_op random_op();
        t_op op;
        int r;
        r = $urandom_range(0, 99);
        op.kind = r < 70 ? KIND_INSERT : r < 82 ? KIND_LOOKUP : r < 91 ? KIND_READ : KIND_LBOUND;
        case ($urandom_range(0, 2))
            0: op.key = {rand64(), rand64(), rand64()};
            1: op.key = {pick_word(), pick_word(), 64'($urandom_range(0, 40))};
            default: begin
                if (leaf_count > 0) op.key = leaf_key[$urandom_range(0, leaf_count - 1)];
                else op.key = {rand64(), rand64(), rand64()};
            end
        endcase
        op.val = {rand64(), rand64()};
        op.pos = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, leaf_count));
        return op;
    endfunction

    function automatic t_dir_row row(t_kind k, t_key key, t_value v, logic [5:0] p,
                                     logic typed, t_status st, logic [5:0] rp);
        t_dir_row d;
        d.op.kind = k;
        d.op.key = key;
        d.op.val = v;
        d.op.pos = p;
        d.typed = typed;
        d.status = st;
        d.pos = rp;
        return d;
    endfunction

    task automatic send_item(t_op op, logic typed, t_status st, logic [5:0] rp);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_kind <= op.kind;
        {i_key_word_2, i_key_word_1, i_key_word_0} <= op.key;
        {i_value_word_1, i_value_word_0} <= op.val;
        i_position <= op.pos;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        apply_leaf_op(op);
        if (typed) begin
            op_results.delete();
            op_results.push_back(make_result(st, rp, '0, '0, 1'b1));
        end
        foreach (op_results[i]) pending_results.push_back(op_results[i]);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [1:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_KEY_WORDS) reg_key_words = data; else reg_value_words = data;
    endtask

    // receiver
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                i_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                n = quiet ? 0 : $urandom_range(0, 16);
                if (n > 0) begin
                    i_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_status, o_result_position,
                    {o_out_key_2, o_out_key_1, o_out_key_0},
                    {o_out_value_1, o_out_value_0}, o_last};
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected item status %0d pos %0d", $time, got.status, got.pos);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.pos != want.pos || got.key != want.key
                    || got.val != want.val || got.last != want.last) begin
                    errors++;
                    $display("%0t: mismatch expected st %0d pos %0d key %h val %h last %0d",
                             $time, want.status, want.pos, want.key, want.val, want.last);
                    $display("%0t:          actual st %0d pos %0d key %h val %h last %0d",
                             $time, got.status, got.pos, got.key, got.val, got.last);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        int idle;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle = 0;
        else
            idle++;
        if (idle >= IdleLimit) begin
            $display("timeout at %0t", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_dir_row dir_tab[$];
        logic [1:0] kw_set[5] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
        logic [1:0] vw_set[5] = '{2'd2, 2'd0, 2'd1, 2'd3, 2'd2};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_tab.push_back(row(KIND_READ, '0, '0, 6'd0, 1, ST_RANGE, 6'd0));
        dir_tab.push_back(row(KIND_READ, '1, '1, 6'd63, 1, ST_RANGE, 6'd63));
        dir_tab.push_back(row(KIND_LOOKUP, '0, '0, 6'd0, 1, ST_NOT_FOUND, 6'd0));
        dir_tab.push_back(row(KIND_LBOUND, '1, '0, 6'd0, 1, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_INSERT, '1, '1, 6'd0, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_INSERT, '0, '0, 6'd0, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_INSERT, '0, '1, 6'd0, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_INSERT, {64'd0, 64'd0, 64'd1}, '1, 6'd0, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_INSERT, {64'd5, {64{1'b1}}, 64'd0}, {64'd7, 64'd9}, 6'd0,
                              0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_LOOKUP, '1, '0, 6'd0, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_LOOKUP, {64'd2, 64'd0, 64'd0}, '0, 6'd0, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_LBOUND, {64'd0, 64'd0, 64'd1}, '0, 6'd0, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_READ, '0, '0, 6'd0, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_READ, '0, '0, 6'd3, 0, ST_OK, 6'd0));
        dir_tab.push_back(row(KIND_READ, '0, '0, 6'd32, 1, ST_RANGE, 6'd32));
        foreach (dir_tab[i]) send_item(dir_tab[i].op, dir_tab[i].typed,
                                       t_status'(dir_tab[i].status), dir_tab[i].pos);
        drain();
        write_reg(CFG_VALUE_WORDS, 2'd2);
        foreach (dir_tab[i]) if (dir_tab[i].op.kind != KIND_INSERT)
            send_item(dir_tab[i].op, 0, ST_OK, 6'd0);

        foreach (kw_set[ph]) begin
            drain();
            write_reg(CFG_KEY_WORDS, kw_set[ph]);
            write_reg(CFG_VALUE_WORDS, vw_set[ph]);
            quiet = (ph == 1);
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 16; n++) send_item(random_op(), 0, ST_OK, 6'd0);
        end
        quiet = 0;
        drain();
        $display("%0d items sent, %0d results checked, %0d leaf splits, five register settings",
                 items_sent, results_seen, splits_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/slt_pkg.sv
design/slt_ram.sv
design/sorted_leaf_table.sv
dv/tb.sv
